### design/pfc_pkg.sv
package pfc_pkg;

   // Letter codes that the cipher treats specially.
   localparam logic [4:0] LETTER_X = 5'd23;
   localparam logic [4:0] LETTER_Q = 5'd16;
   localparam logic [4:0] LETTER_J = 5'd9;

   localparam int ALPHABET = 26;
   localparam int CELLS    = 25;
   localparam int SIDE     = 5;

   // Input item kinds.
   localparam logic [1:0] KIND_KEY_LETTER  = 2'd0;
   localparam logic [1:0] KIND_KEY_END     = 2'd1;
   localparam logic [1:0] KIND_TEXT_LETTER = 2'd2;
   localparam logic [1:0] KIND_TEXT_END    = 2'd3;

   // Commands passed from the front end to the back end.
   localparam logic [1:0] CMD_KEY_LETTER = 2'd0;
   localparam logic [1:0] CMD_KEY_END    = 2'd1;
   localparam logic [1:0] CMD_ERROR      = 2'd2;
   localparam logic [1:0] CMD_PAIR       = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef logic [4:0] letter_type;
   typedef logic [2:0] coord_type;

   typedef struct packed {
      logic [1:0] op;
      letter_type first;
      letter_type second;
   } cmd_type;

   // Row of a cell index; indices past the square wrap back into it.
   function automatic coord_type cell_row(input letter_type pos);
      letter_type p;
      coord_type  row;
      p = (pos >= 5'(CELLS)) ? pos - 5'(CELLS) : pos;
      if (p >= 5'(4 * SIDE)) begin
         row = 3'd4;
      end else if (p >= 5'(3 * SIDE)) begin
         row = 3'd3;
      end else if (p >= 5'(2 * SIDE)) begin
         row = 3'd2;
      end else if (p >= 5'(SIDE)) begin
         row = 3'd1;
      end else begin
         row = 3'd0;
      end
      return row;
   endfunction

   // Cell index from row and column, row * 5 + column.
   function automatic letter_type cell_index(input coord_type row, input coord_type col);
      return (5'(row) << 2) + 5'(row) + 5'(col);
   endfunction

   // Column of a cell index.
   function automatic coord_type cell_col(input letter_type pos);
      letter_type p;
      p = (pos >= 5'(CELLS)) ? pos - 5'(CELLS) : pos;
      return 3'(p - cell_index(cell_row(pos), 3'd0));
   endfunction

   // Next row or column, wrapping at the edge of the square.
   function automatic coord_type coord_next(input coord_type c);
      return (c == 3'(SIDE - 1)) ? 3'd0 : c + 3'd1;
   endfunction

endpackage

### design/pfc_front.sv
module pfc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  pfc_pkg::letter_type req_letter,
   output logic                q_push,
   output pfc_pkg::cmd_type    q_cmd,
   input  logic                q_full
);
   import pfc_pkg::*;

   logic       key_done_ff, key_done_in;
   logic       pending_valid_ff, pending_valid_in;
   letter_type pending_letter_ff, pending_letter_in;
   logic       accept;
   logic       bad_letter;
   logic       gen;

   // An item is taken whenever the queue has room for the command it may cause.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign bad_letter = (req_letter >= 5'(ALPHABET)) || (req_letter == LETTER_J);

   // Classify the item and track the open digraph.
   always_comb begin
      key_done_in       = key_done_ff;
      pending_valid_in  = pending_valid_ff;
      pending_letter_in = pending_letter_ff;
      gen               = 1'b0;
      q_cmd.op          = CMD_ERROR;
      q_cmd.first       = req_letter;
      q_cmd.second      = LETTER_X;
      unique case (req_kind)
         KIND_KEY_LETTER: begin
            if (!key_done_ff) begin
               gen      = 1'b1;
               q_cmd.op = bad_letter ? CMD_ERROR : CMD_KEY_LETTER;
            end
         end
         KIND_KEY_END: begin
            if (!key_done_ff) begin
               gen         = 1'b1;
               q_cmd.op    = CMD_KEY_END;
               key_done_in = 1'b1;
            end
         end
         KIND_TEXT_LETTER: begin
            if (!key_done_ff || bad_letter) begin
               gen = 1'b1;
            end else if (!pending_valid_ff) begin
               pending_valid_in  = 1'b1;
               pending_letter_in = req_letter;
            end else begin
               gen         = 1'b1;
               q_cmd.op    = CMD_PAIR;
               q_cmd.first = pending_letter_ff;
               if (pending_letter_ff != req_letter) begin
                  q_cmd.second      = req_letter;
                  pending_valid_in  = 1'b0;
                  pending_letter_in = '0;
               end else begin
                  // A doubled letter is split; the second copy stays open.
                  q_cmd.second = (req_letter == LETTER_X) ? LETTER_Q : LETTER_X;
               end
            end
         end
         KIND_TEXT_END: begin
            if (!key_done_ff) begin
               gen = 1'b1;
            end else if (pending_valid_ff) begin
               gen               = 1'b1;
               q_cmd.op          = CMD_PAIR;
               q_cmd.first       = pending_letter_ff;
               q_cmd.second      = LETTER_X;
               pending_valid_in  = 1'b0;
               pending_letter_in = '0;
            end
         end
         default: begin
            gen = 1'b0;
         end
      endcase
   end

   assign q_push = accept && gen;

   // State moves only when an item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_done_ff       <= 1'b0;
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
      end else if (accept) begin
         key_done_ff       <= key_done_in;
         pending_valid_ff  <= pending_valid_in;
         pending_letter_ff <= pending_letter_in;
      end
   end

endmodule

### design/pfc_queue.sv
module pfc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfc_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output pfc_pkg::cmd_type head_cmd
);
   import pfc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/pfc_back.sv
module pfc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  pfc_pkg::cmd_type    q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pfc_pkg::letter_type rsp_out_letter,
   output logic                rsp_last,
   output logic                rsp_error
);
   import pfc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_LOOKUP = 3'd2;
   localparam logic [2:0] ST_FIRST  = 3'd3;
   localparam logic [2:0] ST_SECOND = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [ALPHABET-1:0]   used_ff, used_in;
   letter_type            fill_ff, fill_in;
   letter_type            scan_ff, scan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   letter_type            rsp_out_letter_ff;
   logic                  rsp_last_ff, rsp_error_ff;

   letter_type            square_mem [CELLS];
   letter_type            pos_mem [ALPHABET];
   letter_type            pa_ff, pb_ff;
   letter_type            la_ff, lb_ff;

   logic                  out_free;
   logic                  place_en;
   letter_type            place_letter;
   logic                  load_pos, load_sq;
   logic                  load_out;
   letter_type            load_letter;
   logic                  load_last, load_error;
   coord_type             ra, ca, rb, cb;
   letter_type            idx_a, idx_b;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && out_free;
   assign load_pos = q_pop && (q_cmd.op == CMD_PAIR);
   assign load_sq  = (state_ff == ST_LOOKUP);

   // Digraph rule on the two looked-up positions.
   always_comb begin
      ra = cell_row(pa_ff);
      ca = cell_col(pa_ff);
      rb = cell_row(pb_ff);
      cb = cell_col(pb_ff);
      if (ra == rb) begin
         ca = coord_next(cell_col(pa_ff));
         cb = coord_next(cell_col(pb_ff));
      end else if (ca == cb) begin
         ra = coord_next(cell_row(pa_ff));
         rb = coord_next(cell_row(pb_ff));
      end else begin
         ca = cell_col(pb_ff);
         cb = cell_col(pa_ff);
      end
      idx_a = cell_index(ra, ca);
      idx_b = cell_index(rb, cb);
   end

   // Sequencer: key placement, key-end fill walk, error output and digraph output.
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      place_en     = 1'b0;
      place_letter = q_cmd.first;
      load_out     = 1'b0;
      load_letter  = '0;
      load_last    = 1'b1;
      load_error   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               unique case (q_cmd.op)
                  CMD_KEY_LETTER: begin
                     place_en = !used_ff[q_cmd.first] && (fill_ff < 5'(CELLS));
                  end
                  CMD_KEY_END: begin
                     scan_in  = '0;
                     state_in = ST_FILL;
                  end
                  CMD_ERROR: begin
                     load_out   = 1'b1;
                     load_error = 1'b1;
                  end
                  CMD_PAIR: begin
                     state_in = ST_LOOKUP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            place_letter = scan_ff;
            place_en     = (scan_ff != LETTER_J) && !used_ff[scan_ff]
                           && (fill_ff < 5'(CELLS));
            scan_in      = scan_ff + 5'd1;
            if (scan_ff == 5'(ALPHABET - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            if (out_free) begin
               load_out    = 1'b1;
               load_letter = la_ff;
               load_last   = 1'b0;
               state_in    = ST_SECOND;
            end
         end
         ST_SECOND: begin
            if (out_free) begin
               load_out    = 1'b1;
               load_letter = lb_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (place_en) begin
         used_in[place_letter] = 1'b1;
         fill_in               = fill_ff + 5'd1;
      end
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_out_letter_ff <= load_letter;
         rsp_last_ff       <= load_last;
         rsp_error_ff      <= load_error;
      end
   end

   // Square and position stores, with registered reads.
   always_ff @(posedge clock) begin
      if (place_en) begin
         square_mem[fill_ff]    <= place_letter;
         pos_mem[place_letter]  <= fill_ff;
      end
      if (load_pos) begin
         pa_ff <= pos_mem[q_cmd.first];
         pb_ff <= pos_mem[q_cmd.second];
      end
      if (load_sq) begin
         la_ff <= square_mem[idx_a];
         lb_ff <= square_mem[idx_b];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_letter = rsp_out_letter_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error      = rsp_error_ff;

endmodule

### design/playfair_cipher_encrypt_top.sv
// Playfair encryption engine. An item that completes a digraph gives its first result
// after the queue, the back end's position lookup, square read and output register;
// the second follows once the output register is free again.
// A key end starts a walk over the alphabet in the back end; the front end keeps
// taking items while its two-entry queue has room.
// Reset is synchronous: it clears control state and the used-letter flags only.
module playfair_cipher_encrypt_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  pfc_pkg::letter_type req_letter,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pfc_pkg::letter_type rsp_out_letter,
   output logic                rsp_last,
   output logic                rsp_error
);
   import pfc_pkg::*;

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type push_cmd, head_cmd;

   pfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_letter (req_letter),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .q_full     (q_full)
   );

   pfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   pfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (head_cmd),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_letter (rsp_out_letter),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

   // An error item is a single result carrying letter code zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_out_letter == '0))
      else $error("error item is not a lone zero result");

   // The square never holds J, so no ciphertext letter can be J.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> (rsp_out_letter != LETTER_J)
                                  && (rsp_out_letter < 5'(ALPHABET)))
      else $error("ciphertext letter outside the square");

   // The second letter of a digraph follows straight after the first is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("second digraph letter missing");

endmodule
